### design/sliding_window_median_defines.svh
// Assertion macros shared by the sliding-window median design.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SWM_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sliding window median: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SWM_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sliding window median: next-cycle check failed");

`endif

### design/swm_pkg.sv
// Shared types and constants of the sliding-window median filter.
// No dependencies; used by the controller, the datapath and the top level.
package swm_pkg;

   localparam int VALUE_BITS = 8;
   localparam int NUM_BINS   = 1 << VALUE_BITS;
   localparam int MAX_WINDOW = 256;
   localparam int SLOT_BITS  = $clog2(MAX_WINDOW);
   localparam int LEN_BITS   = 9;
   localparam int COUNT_BITS = 9;
   localparam int CUM_BITS   = COUNT_BITS + VALUE_BITS;

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [SLOT_BITS-1:0]  slot_type;
   typedef logic [LEN_BITS-1:0]   len_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [CUM_BITS-1:0]   cum_type;

   localparam count_type COUNT_MAX = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STORE,
      ST_INC,
      ST_DEC_RD,
      ST_DEC,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      BIN_SEL_SAMPLE,
      BIN_SEL_OLD,
      BIN_SEL_SCAN
   } bin_sel_type;

   typedef struct packed {
      logic        accept;
      logic        store_access;
      bin_sel_type bin_sel;
      logic        bin_inc_wr;
      logic        bin_dec_wr;
      logic        scan_clear;
      logic        scan_step;
      logic        load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic emit;
      logic scan_done;
      logic out_free;
   } dp_sts_type;

endpackage

### design/swm_dp.sv
// Datapath of the sliding-window median filter: window store, histogram, scan, output register.
// Depends on swm_pkg and the assertion macros in sliding_window_median_defines.svh.
`include "sliding_window_median_defines.svh"

module swm_dp import swm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  dp_cmd_type cmd,
   output dp_sts_type sts,
   input  logic [7:0] req_tdata,
   input  logic       csr_wen,
   input  logic [8:0] csr_wdata,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata
);

   // Configuration and window bookkeeping.
   len_type   window_len_ff;
   len_type   fill_ff;
   slot_type  wslot_ff;
   len_type   eff_len;
   slot_type  slot_cur;
   len_type   slot_plus;
   slot_type  wslot_in;
   len_type   fill_plus;
   logic      full_cur;
   logic      emit_cur;

   // Per-item registers.
   value_type sample_ff;
   slot_type  slot_ff;
   logic      full_ff;
   logic      emit_ff;
   len_type   target_ff;

   // Window store.
   value_type store_mem_ff [MAX_WINDOW];
   value_type store_rd_ff;

   // Histogram.
   count_type          bin_mem_ff [NUM_BINS];
   logic [NUM_BINS-1:0] bin_valid_ff;
   count_type          bin_rd_ff;
   logic               bin_rd_valid_ff;
   value_type          bin_rd_addr;
   value_type          bin_wr_addr;
   count_type          bin_wr_data;
   logic               bin_wr_en;
   count_type          count_rd;

   // Median scan.
   value_type scan_addr_ff;
   value_type tag_ff;
   logic      pend_ff;
   cum_type   cum_ff;
   cum_type   cum_in;
   logic      hit;
   logic      scan_done;
   value_type med_ff;

   // Output register.
   logic      rsp_valid_ff;
   value_type rsp_data_ff;
   logic      out_free;

   always_comb begin
      if (window_len_ff == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (window_len_ff > LEN_BITS'(MAX_WINDOW)) begin
         eff_len = LEN_BITS'(MAX_WINDOW);
      end else begin
         eff_len = window_len_ff;
      end
   end

   // A write slot left beyond a shortened window wraps to the start.
   assign slot_cur  = (LEN_BITS'(wslot_ff) >= eff_len) ? '0 : wslot_ff;
   assign slot_plus = LEN_BITS'(slot_cur) + LEN_BITS'(1);
   assign wslot_in  = (slot_plus >= eff_len) ? '0 : slot_plus[SLOT_BITS-1:0];
   assign fill_plus = fill_ff + LEN_BITS'(1);
   assign full_cur  = (fill_ff >= eff_len);
   assign emit_cur  = full_cur || (fill_plus >= eff_len);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= LEN_BITS'(1);
         fill_ff       <= '0;
         wslot_ff      <= '0;
      end else begin
         if (csr_wen) begin
            window_len_ff <= csr_wdata;
         end
         if (cmd.accept) begin
            wslot_ff <= wslot_in;
            if (!full_cur) begin
               fill_ff <= fill_plus;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_tdata[VALUE_BITS-1:0];
         slot_ff   <= slot_cur;
         full_ff   <= full_cur;
         emit_ff   <= emit_cur;
         target_ff <= eff_len - (eff_len >> 1);
      end
   end

   // Read-first store: the oldest sample comes out as the new one goes in.
   always_ff @(posedge clock) begin
      if (cmd.store_access) begin
         store_rd_ff            <= store_mem_ff[slot_ff];
         store_mem_ff[slot_ff]  <= sample_ff;
      end
   end

   always_comb begin
      unique case (cmd.bin_sel)
         BIN_SEL_SAMPLE: bin_rd_addr = sample_ff;
         BIN_SEL_OLD:    bin_rd_addr = store_rd_ff;
         BIN_SEL_SCAN:   bin_rd_addr = scan_addr_ff;
         default:        bin_rd_addr = sample_ff;
      endcase
   end

   // Bins never written since reset read as zero.
   assign count_rd    = bin_rd_valid_ff ? bin_rd_ff : '0;
   assign bin_wr_en   = cmd.bin_inc_wr || cmd.bin_dec_wr;
   assign bin_wr_addr = cmd.bin_inc_wr ? sample_ff : store_rd_ff;

   always_comb begin
      if (cmd.bin_inc_wr) begin
         bin_wr_data = (count_rd == COUNT_MAX) ? count_rd : count_rd + COUNT_BITS'(1);
      end else begin
         bin_wr_data = (count_rd == '0) ? count_rd : count_rd - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (bin_wr_en) begin
         bin_mem_ff[bin_wr_addr] <= bin_wr_data;
      end
      bin_rd_ff <= bin_mem_ff[bin_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_valid_ff    <= '0;
         bin_rd_valid_ff <= 1'b0;
      end else begin
         if (bin_wr_en) begin
            bin_valid_ff[bin_wr_addr] <= 1'b1;
         end
         bin_rd_valid_ff <= bin_valid_ff[bin_rd_addr];
      end
   end

   // The scan reads one bin per cycle; its data arrives in the next cycle, together with tag_ff.
   assign cum_in    = cum_ff + CUM_BITS'(count_rd);
   assign hit       = (cum_in >= CUM_BITS'(target_ff));
   assign scan_done = pend_ff && (hit || (tag_ff == '1));

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (cmd.scan_clear) begin
         pend_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         pend_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_clear) begin
         scan_addr_ff <= '0;
         cum_ff       <= '0;
      end else if (cmd.scan_step) begin
         scan_addr_ff <= scan_addr_ff + VALUE_BITS'(1);
         tag_ff       <= scan_addr_ff;
         if (pend_ff) begin
            cum_ff <= cum_in;
         end
         if (scan_done) begin
            med_ff <= tag_ff;
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= med_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 8'(rsp_data_ff);

   assign sts.full      = full_ff;
   assign sts.emit      = emit_ff;
   assign sts.scan_done = scan_done;
   assign sts.out_free  = out_free;

   `SWM_ASSERT_IMPL(a_fill_bound, 1'b1, fill_ff <= LEN_BITS'(MAX_WINDOW))
   `SWM_ASSERT_IMPL(a_scan_ends, cmd.scan_step && pend_ff && (tag_ff == '1), scan_done)
   `SWM_ASSERT_IMPL(a_no_overwrite, cmd.load_out, !rsp_valid_ff || rsp_tready)
   `SWM_ASSERT_NEXT(a_bin_marked, cmd.bin_inc_wr, bin_valid_ff[sample_ff])

endmodule

### design/swm_ctrl.sv
// Controller state machine of the sliding-window median filter.
// Depends on swm_pkg and the assertion macros in sliding_window_median_defines.svh.
`include "sliding_window_median_defines.svh"

module swm_ctrl import swm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store_access = 1'b1;
            cmd.bin_sel      = BIN_SEL_SAMPLE;
            state_in         = ST_INC;
         end
         ST_INC: begin
            cmd.bin_inc_wr = 1'b1;
            cmd.scan_clear = 1'b1;
            if (sts.full) begin
               state_in = ST_DEC_RD;
            end else if (sts.emit) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DEC_RD: begin
            cmd.bin_sel = BIN_SEL_OLD;
            state_in    = ST_DEC;
         end
         ST_DEC: begin
            cmd.bin_dec_wr = 1'b1;
            cmd.scan_clear = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.bin_sel   = BIN_SEL_SCAN;
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `SWM_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)

endmodule

### design/sliding_window_median.sv
// Top level of the sliding-window median filter: controller plus datapath.
// Depends on swm_pkg, swm_ctrl and swm_dp.
//
//   Channel  Dir  Ports                            Beat contents
//   req      in   req_tvalid/req_tready/req_tdata  sample [7:0]
//   rsp      out  rsp_tvalid/rsp_tready/rsp_tdata  median [7:0]
//   csr      in   csr_wen/csr_wdata                window_len [8:0]
//
// A beat that only fills the window passes through the store and increment states
// and returns to idle. A beat that yields a median then runs the scan, after the
// evicted sample's bin is decremented as well once the window is full; the scan walks
// the one-port histogram bin by bin from bin zero up to the median's bin.
// Reset is synchronous and active high; it clears the histogram valid bits, the
// fill level and the write slot, and sets window_len to one.
// The finished median waits in an output register, so a stalled rsp side only
// holds the controller once a second median is ready to be loaded.
module sliding_window_median import swm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] sample
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] median
   input  logic       csr_wen,
   input  logic [8:0] csr_wdata     // [8:0] window_len
);

   // Commands flow from the controller to the datapath; status flows back.
   dp_cmd_type cmd;
   dp_sts_type sts;

   // The controller sequences each beat: store access, histogram increment,
   // optional decrement of the evicted sample's bin, then the median scan if one is due.
   swm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath owns the window store, the histogram, the running sum of
   // the scan and the output register.
   swm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
